// ===== hw/rtl/saturating_signed_alu_top_macros.svh =====
// Assertion macros shared by the checker of the saturating ALU.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef SATURATING_SIGNED_ALU_TOP_MACROS_SVH
`define SATURATING_SIGNED_ALU_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSALU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SSALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ssalu_pkg.sv =====
// Shared types and constants of the saturating ALU.
// No dependencies; used by the interfaces, controller, datapath and top level.
package ssalu_pkg;

   localparam int OPCODE_WIDTH  = 4;
   localparam int OPERAND_WIDTH = 32;
   localparam int RESULT_WIDTH  = 32;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_AND  = 4'd0,
      OP_OR   = 4'd1,
      OP_XOR  = 4'd2,
      OP_NOT  = 4'd3,
      OP_ADD  = 4'd4,
      OP_SUB  = 4'd5,
      OP_MUL  = 4'd6,
      OP_DIV  = 4'd7,
      OP_INC  = 4'd8,
      OP_DEC  = 4'd9,
      OP_LOAD = 4'd10
   } opcode_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch the request word
      logic prepare;   // compute simple result, set up the iterative unit
      logic step;      // one shift-add or shift-subtract step
      logic commit;    // write result register and, if chosen, accumulator
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic iterative; // latched opcode is multiply or divide
      logic out_free;  // result register can take a word this cycle
   } status_type;

endpackage

// ===== hw/rtl/ssalu_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on ssalu_pkg for field widths.
interface ssalu_req_if;
   import ssalu_pkg::*;

   logic                            valid;
   logic                            ready;
   logic        [OPCODE_WIDTH-1:0]  opcode;
   logic signed [OPERAND_WIDTH-1:0] operand;
   logic                            to_accumulator;

   modport source (output valid, output opcode, output operand, output to_accumulator,
                   input ready);
   modport sink   (input valid, input opcode, input operand, input to_accumulator,
                   output ready);
endinterface

interface ssalu_rsp_if;
   import ssalu_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [RESULT_WIDTH-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

// ===== hw/rtl/saturating_signed_alu_top.sv =====
// Saturating signed accumulator ALU, top level.
// Depends on ssalu_pkg, ssalu_if, ssalu_ctrl and ssalu_datapath.
//
// The block holds one DATA_WIDTH-bit signed accumulator (reset to zero) and
// combines it with the operand of each request word under its opcode; every
// arithmetic result saturates to the signed range, divide by zero gives the
// maximum, and to_accumulator chooses whether the result is written back.
// One word is in work at a time. Logic ops, add, subtract, increment,
// decrement, load and unused opcodes pass through accept, execute and
// commit; multiply and divide also iterate between execute and commit in
// the shared shift-add/shift-subtract unit, which retires one operand bit
// per cycle. The result register decouples the response side: a new request
// word is taken while the previous result still waits, and a full result
// register stalls only the commit of the next one.
module saturating_signed_alu_top #(
   parameter int DATA_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   ssalu_req_if.sink   req_ch,
   ssalu_rsp_if.source rsp_ch
);
   import ssalu_pkg::*;

   cmd_type    cmd;
   status_type status;

   ssalu_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssalu_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_ch.opcode),
      .req_operand        (req_ch.operand),
      .req_to_accumulator (req_ch.to_accumulator),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_result         (rsp_ch.result)
   );

endmodule

// ===== hw/rtl/ssalu_ctrl.sv =====
// Controller state machine of the saturating ALU: sequences capture,
// execute, iterate and commit. Depends on ssalu_pkg for command/status types.
module ssalu_ctrl #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ssalu_pkg::status_type status,
   output ssalu_pkg::cmd_type    cmd
);
   import ssalu_pkg::*;

   localparam int CNT_WIDTH = $clog2(DATA_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(DATA_WIDTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_ITER   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.prepare = 1'b1;
            cnt_in      = '0;
            state_in    = status.iterative ? ST_ITER : ST_FINISH;
         end
         ST_ITER: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and step count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/ssalu_datapath.sv =====
// Datapath of the saturating ALU: accumulator, saturating adder, shared
// shift-add/shift-subtract unit and result register. Depends on ssalu_pkg.
module ssalu_datapath #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic        [ssalu_pkg::OPCODE_WIDTH-1:0]  req_opcode,
   input  logic signed [ssalu_pkg::OPERAND_WIDTH-1:0] req_operand,
   input  logic                                      req_to_accumulator,
   input  ssalu_pkg::cmd_type                        cmd,
   output ssalu_pkg::status_type                     status,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [ssalu_pkg::RESULT_WIDTH-1:0]  rsp_result
);
   import ssalu_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int XO = (W > OPERAND_WIDTH) ? W : OPERAND_WIDTH;
   localparam int XR = (W > RESULT_WIDTH) ? W : RESULT_WIDTH;
   localparam logic [W-1:0] INT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] INT_MIN = {1'b1, {(W-1){1'b0}}};

   // Captured request word
   logic [OPCODE_WIDTH-1:0] op_ff;
   logic [W-1:0]            opnd_ff;
   logic                    wr_ff;
   logic [XO-1:0]           opnd_ext;

   // Architectural and working registers
   logic [W-1:0]   acc_ff;
   logic [W-1:0]   res_ff;
   logic [W-1:0]   addend_ff, addend_in;
   logic [2*W-1:0] prod_ff, prod_in;
   logic           neg_ff, zero_div_ff;

   // Result register
   logic                           rsp_valid_ff;
   logic signed [RESULT_WIDTH-1:0] rsp_result_ff;
   logic [XR-1:0]                  res_ext;

   logic           is_mul, is_div;
   logic [W:0]     add_a, add_b, add_sum;
   logic           add_cin;
   logic [W-1:0]   sat_sum, simple_res;
   logic [W-1:0]   mag_a, mag_b;
   logic [W:0]     mul_hi;
   logic [W-1:0]   div_shift;
   logic [W:0]     div_diff;
   logic [W-1:0]   lim, clamp, iter_res, final_res;
   logic [2*W-1:0] wide_mag;

   assign opnd_ext = XO'(req_operand);
   assign is_mul   = (op_ff == OP_MUL);
   assign is_div   = (op_ff == OP_DIV);

   assign status.iterative = op_ff inside {OP_MUL, OP_DIV};
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Share one adder among add, subtract, increment and decrement
   always_comb begin
      add_a   = {acc_ff[W-1], acc_ff};
      add_b   = '0;
      add_cin = 1'b0;
      case (op_ff)
         OP_ADD: begin
            add_b = {opnd_ff[W-1], opnd_ff};
         end
         OP_SUB: begin
            add_b   = ~{opnd_ff[W-1], opnd_ff};
            add_cin = 1'b1;
         end
         OP_INC: begin
            add_cin = 1'b1;
         end
         OP_DEC: begin
            add_b = '1;
         end
         default: begin
            add_b = '0;
         end
      endcase
      add_sum = add_a + add_b + (W+1)'(add_cin);
      if (add_sum[W] != add_sum[W-1]) begin
         sat_sum = add_sum[W] ? INT_MIN : INT_MAX;
      end else begin
         sat_sum = add_sum[W-1:0];
      end
   end

   // Select the simple (non-iterative) result
   always_comb begin
      case (op_ff)
         OP_AND:                         simple_res = acc_ff & opnd_ff;
         OP_OR:                          simple_res = acc_ff | opnd_ff;
         OP_XOR:                         simple_res = acc_ff ^ opnd_ff;
         OP_NOT:                         simple_res = ~acc_ff;
         OP_ADD, OP_SUB, OP_INC, OP_DEC: simple_res = sat_sum;
         OP_LOAD:                        simple_res = opnd_ff;
         default:                        simple_res = acc_ff;
      endcase
   end

   // Magnitudes of both operands
   assign mag_a = acc_ff[W-1]  ? (W'(0) - acc_ff)  : acc_ff;
   assign mag_b = opnd_ff[W-1] ? (W'(0) - opnd_ff) : opnd_ff;

   // Set up or advance the shift-add / shift-subtract unit
   always_comb begin
      mul_hi    = {1'b0, prod_ff[2*W-1:W]} + {1'b0, (prod_ff[0] ? addend_ff : W'(0))};
      div_shift = {prod_ff[2*W-2:W], prod_ff[W-1]};
      div_diff  = {1'b0, div_shift} - {1'b0, addend_ff};
      addend_in = addend_ff;
      prod_in   = prod_ff;
      if (cmd.prepare) begin
         addend_in = is_mul ? mag_a : mag_b;
         prod_in   = {W'(0), (is_mul ? mag_b : mag_a)};
      end else if (cmd.step) begin
         if (is_mul) begin
            prod_in = {mul_hi, prod_ff[W-1:1]};
         end else begin
            prod_in = {(div_diff[W] ? div_shift : div_diff[W-1:0]),
                       prod_ff[W-2:0], ~div_diff[W]};
         end
      end
   end

   // Saturate the iterative result to the limit of its true sign
   always_comb begin
      lim      = neg_ff ? INT_MIN : INT_MAX;
      wide_mag = is_mul ? prod_ff : {W'(0), prod_ff[W-1:0]};
      clamp    = (wide_mag > {W'(0), lim}) ? lim : wide_mag[W-1:0];
      if (is_div && zero_div_ff) begin
         iter_res = INT_MAX;
      end else begin
         iter_res = neg_ff ? (W'(0) - clamp) : clamp;
      end
      final_res = status.iterative ? iter_res : res_ff;
   end

   assign res_ext = XR'(signed'(final_res));

   // Capture request, hold working values
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         opnd_ff <= opnd_ext[W-1:0];
         wr_ff   <= req_to_accumulator;
      end
      if (cmd.prepare) begin
         res_ff      <= simple_res;
         neg_ff      <= acc_ff[W-1] ^ opnd_ff[W-1];
         zero_div_ff <= (opnd_ff == W'(0));
      end
      addend_ff <= addend_in;
      prod_ff   <= prod_in;
      if (cmd.commit) begin
         rsp_result_ff <= res_ext[RESULT_WIDTH-1:0];
      end
   end

   // Update accumulator and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit && wr_ff) begin
            acc_ff <= final_res;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

// ===== hw/rtl/ssalu_checker.sv =====
// Port-level checker of the saturating ALU and its bind to the top level.
// Depends on saturating_signed_alu_top_macros.svh and ssalu_pkg.
`include "saturating_signed_alu_top_macros.svh"

module ssalu_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_valid,
   input logic                                      req_ready,
   input logic                                      rsp_valid,
   input logic                                      rsp_ready,
   input logic signed [ssalu_pkg::RESULT_WIDTH-1:0]  rsp_result
);
   import ssalu_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Count words accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_take && !rsp_take) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `SSALU_ASSERT_NOW(a_no_phantom_result, clock, reset, rsp_valid, (pend_ff != 2'd0), "result without a pending request")
   `SSALU_ASSERT_NOW(a_one_in_work, clock, reset, req_ready, (pend_ff != 2'd2), "request taken while one is still in work")
   `SSALU_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, (rsp_valid && !rsp_ready), rsp_valid, "result dropped before taken")
   `SSALU_ASSERT_NEXT(a_rsp_result_holds, clock, reset, (rsp_valid && !rsp_ready), $stable(rsp_result), "stalled result changed")

endmodule

bind saturating_signed_alu_top ssalu_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_result (rsp_ch.result)
);

// ===== tb/tb_saturating_signed_alu_top.sv =====
// Self-checking bench for the saturating signed accumulator ALU.
// Depends on ssalu_pkg, ssalu_if and saturating_signed_alu_top; runs directed words, then random.
module tb_saturating_signed_alu_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ssalu_pkg::*;

   typedef logic signed [RESULT_WIDTH-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};
   localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED_TOP = '1;
   localparam int DIRECTED_COUNT = 27;
   localparam int RANDOM_WORDS   = 400;
   localparam int PHASE_WORDS    = 50;
   localparam int IDLE_LIMIT     = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [OPCODE_WIDTH-1:0] opcode;
      word_type                operand;
      logic                    to_acc;
      bit                      typed;
      word_type                result;
   } directed_row_type;

   logic clock;
   logic reset;

   ssalu_req_if req_ch ();
   ssalu_rsp_if rsp_ch ();

   saturating_signed_alu_top #(
      .DATA_WIDTH(RESULT_WIDTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Directed words: limits, every opcode, divide by zero, minimum by minus one,
   // multiply overflow, increment at maximum and decrement at minimum
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{OP_OR,         0,                 1'b0, 1'b1, 0},
      '{OP_LOAD,       WORD_MAX,          1'b1, 1'b1, WORD_MAX},
      '{OP_INC,        0,                 1'b0, 1'b1, WORD_MAX},
      '{OP_ADD,        1,                 1'b0, 1'b1, WORD_MAX},
      '{OP_MUL,        2,                 1'b0, 1'b1, WORD_MAX},
      '{OP_MUL,        -2,                1'b0, 1'b1, WORD_MIN},
      '{OP_DIV,        0,                 1'b0, 1'b1, WORD_MAX},
      '{OP_NOT,        0,                 1'b0, 1'b1, WORD_MIN},
      '{OP_SUB,        -1,                1'b0, 1'b1, WORD_MAX},
      '{OP_LOAD,       WORD_MIN,          1'b1, 1'b1, WORD_MIN},
      '{OP_DEC,        0,                 1'b0, 1'b1, WORD_MIN},
      '{OP_SUB,        1,                 1'b0, 1'b1, WORD_MIN},
      '{OP_ADD,        -1,                1'b0, 1'b1, WORD_MIN},
      '{OP_DIV,        -1,                1'b0, 1'b1, WORD_MAX},
      '{OP_MUL,        -1,                1'b0, 1'b1, WORD_MAX},
      '{OP_MUL,        WORD_MIN,          1'b0, 1'b1, WORD_MAX},
      '{OP_DIV,        0,                 1'b0, 1'b1, WORD_MAX},
      '{OP_SUB,        WORD_MIN,          1'b0, 1'b0, 0},
      '{OP_XOR,        32'sh5555_5555,    1'b1, 1'b0, 0},
      '{OP_AND,        32'sh70F0_0FF0,    1'b0, 1'b0, 0},
      '{OP_UNUSED_TOP, -1,                1'b1, 1'b0, 0},
      '{OP_LOAD,       -7,                1'b1, 1'b1, -7},
      '{OP_DIV,        2,                 1'b0, 1'b1, -3},
      '{OP_MUL,        3,                 1'b1, 1'b1, -21},
      '{OP_INC,        0,                 1'b1, 1'b0, 0},
      '{OP_DEC,        0,                 1'b1, 1'b0, 0},
      '{OP_OR,         32'sh0F0F_0000,    1'b1, 1'b0, 0}
   };

   word_type pending_results [$];
   word_type acc_value;
   int       mismatch_count;
   int       sender_gap_pct;
   int       rsp_stall_pct;
   int       stall_left;
   int       idle_cycles;

   // Free-running clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic word_type clamp_word(input longint value);
      if (value > longint'(WORD_MAX)) return WORD_MAX;
      if (value < longint'(WORD_MIN)) return WORD_MIN;
      return word_type'(value);
   endfunction

   // Saturating ALU result for one word against the current accumulator
   function automatic word_type compute_alu_word(input logic [OPCODE_WIDTH-1:0] op,
                                                 input word_type acc, input word_type arg);
      longint   a_wide;
      longint   b_wide;
      word_type value;
      a_wide = acc;
      b_wide = arg;
      case (op)
         OP_AND:  value = acc & arg;
         OP_OR:   value = acc | arg;
         OP_XOR:  value = acc ^ arg;
         OP_NOT:  value = ~acc;
         OP_ADD:  value = clamp_word(a_wide + b_wide);
         OP_SUB:  value = clamp_word(a_wide - b_wide);
         OP_MUL:  value = clamp_word(a_wide * b_wide);
         OP_DIV:  value = (arg == 0) ? WORD_MAX : clamp_word(a_wide / b_wide);
         OP_INC:  value = clamp_word(a_wide + 1);
         OP_DEC:  value = clamp_word(a_wide - 1);
         OP_LOAD: value = arg;
         default: value = acc;
      endcase
      return value;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   // Operands lean toward the limits and small values, the rest full range
   function automatic word_type pick_operand();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
         case ($urandom_range(0, 4))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return 0;
            3:       return 1;
            default: return -1;
         endcase
      end
      if (roll < 60) return word_type'($urandom_range(0, 200)) - 100;
      return word_type'($urandom());
   endfunction

   task automatic note_mismatch(input string what, input word_type want,
                                input word_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s: expected %0d (0x%h), got %0d (0x%h)",
                  $realtime, what, want, want, got, got);
   endtask

   // Present one word, wait for its handshake, queue its result
   task automatic drive_word(input logic [OPCODE_WIDTH-1:0] op, input word_type arg,
                             input logic wr, input bit has_typed,
                             input word_type typed_value, input bit hold_for_drain);
      int       gap;
      word_type value;
      gap = 0;
      if (sender_gap_pct > 0 && $urandom_range(0, 99) < sender_gap_pct)
         gap = pick_gap();
      if (gap > 0 || hold_for_drain) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         if (hold_for_drain) begin
            do @(posedge clock); while (pending_results.size() != 0);
         end
      end
      req_ch.valid          <= 1'b1;
      req_ch.opcode         <= op;
      req_ch.operand        <= arg;
      req_ch.to_accumulator <= wr;
      do @(posedge clock); while (!req_ch.ready);
      value = compute_alu_word(op, acc_value, arg);
      pending_results.push_back(has_typed ? typed_value : value);
      if (wr)
         acc_value = value;
   endtask

   // Check each result word and pace the response ready
   always @(posedge clock) begin : rsp_side
      word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected result", 0, rsp_ch.result);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.result !== want)
               note_mismatch("result mismatch", want, rsp_ch.result);
         end
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (rsp_stall_pct > 0 && $urandom_range(0, 99) < rsp_stall_pct)
            stall_left = pick_gap();
      end
   end

   // Abort when neither side moves a word for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [OPCODE_WIDTH-1:0] op;
      int                      roll;
      int                      phase;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.opcode         <= OP_AND;
      req_ch.operand        <= 0;
      req_ch.to_accumulator <= 1'b0;
      acc_value      = 0;
      mismatch_count = 0;
      stall_left     = 0;
      sender_gap_pct = 20;
      rsp_stall_pct  = 20;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed_rows[i])
         drive_word(directed_rows[i].opcode, directed_rows[i].operand,
                    directed_rows[i].to_acc, directed_rows[i].typed,
                    directed_rows[i].result, 1'b0);

      // Random words, idling varied by phase; one phase runs with no idling
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         phase = (n / PHASE_WORDS) % 4;
         case (phase)
            0:       begin sender_gap_pct = 25; rsp_stall_pct = 15; end
            1:       begin sender_gap_pct = 10; rsp_stall_pct = 50; end
            2:       begin sender_gap_pct = 50; rsp_stall_pct = 5;  end
            default: begin sender_gap_pct = 0;  rsp_stall_pct = 0;  end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 8)
            op = OPCODE_WIDTH'($urandom_range(int'(OP_LOAD) + 1, int'(OP_UNUSED_TOP)));
         else
            op = OPCODE_WIDTH'($urandom_range(int'(OP_AND), int'(OP_LOAD)));
         drive_word(op, pick_operand(), $urandom_range(0, 99) < 60, 1'b0, 0,
                    n == RANDOM_WORDS / 2);
      end
      req_ch.valid <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== saturating_signed_alu_top.f =====
+incdir+hw/rtl
hw/rtl/ssalu_pkg.sv
hw/rtl/ssalu_if.sv
hw/rtl/ssalu_ctrl.sv
hw/rtl/ssalu_datapath.sv
hw/rtl/saturating_signed_alu_top.sv
hw/rtl/ssalu_checker.sv
tb/tb_saturating_signed_alu_top.sv
